// File: hw/rtl/best_fit_coalescing_allocator_macros.svh
// Assertion macros for the best-fit coalescing allocator.
`ifndef BEST_FIT_COALESCING_ALLOCATOR_MACROS_SVH
`define BEST_FIT_COALESCING_ALLOCATOR_MACROS_SVH

// Same-cycle implication.
`define BFCA_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define BFCA_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/bfca_pkg.sv
// Package: types and constants of the best-fit coalescing allocator.
`timescale 1ns / 1ps
package bfca_pkg;

   localparam int BFCA_MAX_BLOCKS = 256;
   localparam int ADDR_W = 12;
   localparam int GRANULE_SHIFT = 10;
   localparam int GRANULE_BYTES = 1 << GRANULE_SHIFT;

   localparam logic [30:0] POOL_RESET = 31'd1048576;
   localparam logic [30:0] POOL_MAX = 31'd1073741824;
   localparam logic [40:0] USED_MAX = '1;

   localparam logic [1:0] OWN_FREE = 2'd0;
   localparam logic [1:0] OWN_INFER = 2'd1;
   localparam logic [1:0] OWN_TRAIN = 2'd2;

   localparam logic [2:0] ST_OK = 3'd0;
   localparam logic [2:0] ST_NULL = 3'd1;
   localparam logic [2:0] ST_NOFIT = 3'd2;
   localparam logic [2:0] ST_NOTALLOC = 3'd3;
   localparam logic [2:0] ST_FULL = 3'd4;

   typedef struct packed {
      logic        mode;
      logic [39:0] request_bytes;
      logic        mem_kind;
      logic [29:0] block_offset;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [29:0] grant_offset;
      logic [30:0] grant_granules;
      logic [40:0] kind_used_bytes;
   } rsp_type;

   typedef struct packed {
      logic [29:0] start;
      logic [30:0] len;
      logic [1:0]  owner;
      logic [31:0] stamp;
   } entry_type;

   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      entry_type         wr_data;
      logic              vset_en;
      logic [ADDR_W-1:0] vset_addr;
      logic              vclr0_en;
      logic [ADDR_W-1:0] vclr0_addr;
      logic              vclr1_en;
      logic [ADDR_W-1:0] vclr1_addr;
      logic              init;
   } table_cmd_type;

endpackage

// File: hw/rtl/bfca_table.sv
// Block table: entry memory with registered read, plus per-entry valid flops.
`timescale 1ns / 1ps
module bfca_table #(
   parameter int MAX_BLOCKS = bfca_pkg::BFCA_MAX_BLOCKS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  bfca_pkg::table_cmd_type       cmd,
   input  logic [$clog2(MAX_BLOCKS)-1:0] rd_addr,
   output bfca_pkg::entry_type           rd_entry,
   output logic                          rd_valid
);
   import bfca_pkg::*;

   localparam int IDX_W = $clog2(MAX_BLOCKS);

   entry_type             mem_ff [MAX_BLOCKS];
   entry_type             rd_entry_ff;
   logic                  rd_valid_ff;
   logic [MAX_BLOCKS-1:0] valid_ff;
   logic [MAX_BLOCKS-1:0] valid_in;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem_ff[cmd.wr_addr[IDX_W-1:0]] <= cmd.wr_data;
      end
      rd_entry_ff <= mem_ff[rd_addr];
      rd_valid_ff <= valid_ff[rd_addr];
   end

   always_comb begin
      valid_in = valid_ff;
      if (cmd.init) begin
         valid_in = '0;
         valid_in[0] = 1'b1;
      end else begin
         if (cmd.vset_en) begin
            valid_in[cmd.vset_addr[IDX_W-1:0]] = 1'b1;
         end
         if (cmd.vclr0_en) begin
            valid_in[cmd.vclr0_addr[IDX_W-1:0]] = 1'b0;
         end
         if (cmd.vclr1_en) begin
            valid_in[cmd.vclr1_addr[IDX_W-1:0]] = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= MAX_BLOCKS'(1);
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign rd_entry = rd_entry_ff;
   assign rd_valid = rd_valid_ff;

endmodule

// File: hw/rtl/best_fit_coalescing_allocator.sv
// Top level: best-fit pool allocator with coalescing over a block table.
//
// Requests arrive on req_valid/req_stall/req_payload; one transaction per
// request. Results leave on rsp_valid/rsp_stall/rsp_payload, one per request.
// The pool size register is written with csr_write_en/csr_write_data while
// the block is idle; a write re-initializes the table and byte counts.
// An allocate scans the whole table once for the best fit and a free slot,
// then updates the table in the ADEC and ASPLIT states. A free scans the
// table for the owned block and then, if it was found, scans it again for
// free neighbors. Zero-byte allocates skip the scan. The scan through the
// single read port of the entry memory allows only one request at a time.
// Reset (synchronous) restores a pool of 1048576 granules as one free block;
// after reset or a pool write, state INIT writes entry 0 before requests are
// taken. A finished result sits in an output register; if the receiver
// stalls, the next request is still accepted and processed, and only its
// final hand-off waits until the output register frees up.
`timescale 1ns / 1ps
`include "best_fit_coalescing_allocator_macros.svh"
module best_fit_coalescing_allocator #(
   parameter int MAX_BLOCKS = bfca_pkg::BFCA_MAX_BLOCKS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  bfca_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output bfca_pkg::rsp_type rsp_payload,
   input  logic              csr_write_en,
   input  logic [30:0]       csr_write_data
);
   import bfca_pkg::*;

   localparam int IDX_W = $clog2(MAX_BLOCKS);
   localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_BLOCKS);

   typedef enum logic [8:0] {
      S_INIT    = 9'b000000001,
      S_IDLE    = 9'b000000010,
      S_ASCAN   = 9'b000000100,
      S_ADEC    = 9'b000001000,
      S_ASPLIT  = 9'b000010000,
      S_FSCAN1  = 9'b000100000,
      S_FSCAN2  = 9'b001000000,
      S_FCOMMIT = 9'b010000000,
      S_RESP    = 9'b100000000
   } state_type;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [30:0]       pool_ff, pool_in;
   logic [31:0]       stamp_ff, stamp_in;
   logic [40:0]       used0_ff, used0_in, used1_ff, used1_in;
   req_type           req_ff, req_in;
   logic [30:0]       need_ff, need_in;
   logic              best_found_ff, best_found_in;
   logic [IDX_W-1:0]  best_idx_ff, best_idx_in;
   entry_type         best_ff, best_in;
   logic              slot_found_ff, slot_found_in;
   logic [IDX_W-1:0]  slot_idx_ff, slot_idx_in;
   logic              e_found_ff, e_found_in;
   logic [IDX_W-1:0]  e_idx_ff, e_idx_in;
   entry_type         e_ff, e_in;
   logic              prev_found_ff, prev_found_in;
   logic [IDX_W-1:0]  prev_idx_ff, prev_idx_in;
   entry_type         prev_ff, prev_in;
   logic              next_found_ff, next_found_in;
   logic [IDX_W-1:0]  next_idx_ff, next_idx_in;
   logic [30:0]       next_len_ff, next_len_in;
   rsp_type           pend_ff, pend_in;
   rsp_type           rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;

   table_cmd_type     cmd;
   entry_type         rd_entry;
   logic              rd_valid;
   logic [IDX_W-1:0]  rd_addr;

   logic              proc;
   logic              scan_done;
   logic [IDX_W-1:0]  scan_idx;
   logic [40:0]       need_sum;
   logic [40:0]       req_used;
   logic [31:0]       free_end;
   logic [31:0]       rd_end;
   logic [41:0]       add_sum;
   logic [40:0]       add_used;
   logic              free_kind;
   logic [40:0]       sub_amt;
   logic [40:0]       sub_base;
   logic [40:0]       sub_used;
   logic [30:0]       merge_len;
   logic [30:0]       csr_clamped;
   logic              better;

   bfca_table #(.MAX_BLOCKS(MAX_BLOCKS)) u_table (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .rd_addr  (rd_addr),
      .rd_entry (rd_entry),
      .rd_valid (rd_valid)
   );

   // Entry cnt-1 is on the read port while address cnt is issued.
   assign rd_addr   = cnt_ff[IDX_W-1:0];
   assign proc      = (cnt_ff != '0);
   assign scan_done = (cnt_ff == CNT_LAST);
   assign scan_idx  = IDX_W'(cnt_ff - CNT_W'(1));

   assign need_sum = {1'b0, req_payload.request_bytes} + 41'(GRANULE_BYTES - 1);
   assign req_used = req_ff.mem_kind ? used1_ff : used0_ff;
   assign free_end = {2'b0, req_ff.block_offset} + {1'b0, e_ff.len};
   assign rd_end   = {2'b0, rd_entry.start} + {1'b0, rd_entry.len};

   assign add_sum  = {1'b0, req_used} + {1'b0, 41'(need_ff) << GRANULE_SHIFT};
   assign add_used = add_sum[41] ? USED_MAX : add_sum[40:0];

   assign free_kind = (e_ff.owner == OWN_TRAIN);
   assign sub_amt   = 41'(e_ff.len) << GRANULE_SHIFT;
   assign sub_base  = free_kind ? used1_ff : used0_ff;
   assign sub_used  = (sub_base < sub_amt) ? '0 : (sub_base - sub_amt);
   assign merge_len = e_ff.len + (next_found_ff ? next_len_ff : 31'd0);

   assign better = !best_found_ff || (rd_entry.len < best_ff.len) ||
                   ((rd_entry.len == best_ff.len) && (rd_entry.stamp < best_ff.stamp));

   always_comb begin
      csr_clamped = csr_write_data;
      if (csr_write_data == 31'd0) begin
         csr_clamped = 31'd1;
      end else if (csr_write_data > POOL_MAX) begin
         csr_clamped = POOL_MAX;
      end
   end

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      pool_in       = pool_ff;
      stamp_in      = stamp_ff;
      used0_in      = used0_ff;
      used1_in      = used1_ff;
      req_in        = req_ff;
      need_in       = need_ff;
      best_found_in = best_found_ff;
      best_idx_in   = best_idx_ff;
      best_in       = best_ff;
      slot_found_in = slot_found_ff;
      slot_idx_in   = slot_idx_ff;
      e_found_in    = e_found_ff;
      e_idx_in      = e_idx_ff;
      e_in          = e_ff;
      prev_found_in = prev_found_ff;
      prev_idx_in   = prev_idx_ff;
      prev_in       = prev_ff;
      next_found_in = next_found_ff;
      next_idx_in   = next_idx_ff;
      next_len_in   = next_len_ff;
      pend_in       = pend_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      cmd           = '0;

      unique case (state_ff)
         S_INIT: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_data = '{start: '0, len: pool_ff, owner: OWN_FREE, stamp: '0};
            state_in    = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               req_in        = req_payload;
               need_in       = 31'(need_sum >> GRANULE_SHIFT);
               cnt_in        = '0;
               best_found_in = 1'b0;
               slot_found_in = 1'b0;
               e_found_in    = 1'b0;
               prev_found_in = 1'b0;
               next_found_in = 1'b0;
               if (req_payload.mode) begin
                  state_in = S_FSCAN1;
               end else if (req_payload.request_bytes == '0) begin
                  pend_in = '{status: ST_NULL, grant_offset: '0, grant_granules: '0,
                     kind_used_bytes: req_payload.mem_kind ? used1_ff : used0_ff};
                  state_in = S_RESP;
               end else begin
                  state_in = S_ASCAN;
               end
            end
         end
         S_ASCAN: begin
            if (proc && rd_valid && (rd_entry.owner == OWN_FREE) &&
                (rd_entry.len >= need_ff) && better) begin
               best_found_in = 1'b1;
               best_idx_in   = scan_idx;
               best_in       = rd_entry;
            end
            if (proc && !rd_valid && !slot_found_ff) begin
               slot_found_in = 1'b1;
               slot_idx_in   = scan_idx;
            end
            if (scan_done) begin
               cnt_in   = '0;
               state_in = S_ADEC;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         S_ADEC: begin
            if (!best_found_ff) begin
               pend_in  = '{status: ST_NOFIT, grant_offset: '0, grant_granules: '0,
                  kind_used_bytes: req_used};
               state_in = S_RESP;
            end else if (best_ff.len > need_ff) begin
               if (!slot_found_ff) begin
                  pend_in  = '{status: ST_FULL, grant_offset: '0, grant_granules: '0,
                     kind_used_bytes: req_used};
                  state_in = S_RESP;
               end else begin
                  // remainder becomes a new free block
                  cmd.wr_en     = 1'b1;
                  cmd.wr_addr   = ADDR_W'(slot_idx_ff);
                  cmd.wr_data   = '{start: 30'(best_ff.start + need_ff),
                     len: best_ff.len - need_ff, owner: OWN_FREE, stamp: stamp_ff};
                  cmd.vset_en   = 1'b1;
                  cmd.vset_addr = ADDR_W'(slot_idx_ff);
                  stamp_in      = stamp_ff + 32'd1;
                  state_in      = S_ASPLIT;
               end
            end else begin
               state_in = S_ASPLIT;
            end
         end
         S_ASPLIT: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_addr = ADDR_W'(best_idx_ff);
            cmd.wr_data = '{start: best_ff.start, len: need_ff,
               owner: req_ff.mem_kind ? OWN_TRAIN : OWN_INFER, stamp: best_ff.stamp};
            if (req_ff.mem_kind) begin
               used1_in = add_used;
            end else begin
               used0_in = add_used;
            end
            pend_in  = '{status: ST_OK, grant_offset: best_ff.start,
               grant_granules: need_ff, kind_used_bytes: add_used};
            state_in = S_RESP;
         end
         S_FSCAN1: begin
            if (proc && rd_valid && (rd_entry.owner != OWN_FREE) &&
                (rd_entry.start == req_ff.block_offset) && !e_found_ff) begin
               e_found_in = 1'b1;
               e_idx_in   = scan_idx;
               e_in       = rd_entry;
            end
            if (scan_done) begin
               cnt_in   = '0;
               state_in = S_FSCAN2;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         S_FSCAN2: begin
            if (!e_found_ff) begin
               pend_in  = '{status: ST_NOTALLOC, grant_offset: '0, grant_granules: '0,
                  kind_used_bytes: req_used};
               state_in = S_RESP;
            end else begin
               if (proc && rd_valid && (rd_entry.owner == OWN_FREE)) begin
                  if ((rd_end == {2'b0, req_ff.block_offset}) && !prev_found_ff) begin
                     prev_found_in = 1'b1;
                     prev_idx_in   = scan_idx;
                     prev_in       = rd_entry;
                  end else if (({2'b0, rd_entry.start} == free_end) && !next_found_ff) begin
                     next_found_in = 1'b1;
                     next_idx_in   = scan_idx;
                     next_len_in   = rd_entry.len;
                  end
               end
               if (scan_done) begin
                  cnt_in   = '0;
                  state_in = S_FCOMMIT;
               end else begin
                  cnt_in = cnt_ff + CNT_W'(1);
               end
            end
         end
         S_FCOMMIT: begin
            cmd.wr_en      = 1'b1;
            cmd.vclr1_en   = next_found_ff;
            cmd.vclr1_addr = ADDR_W'(next_idx_ff);
            if (prev_found_ff) begin
               cmd.wr_addr    = ADDR_W'(prev_idx_ff);
               cmd.wr_data    = '{start: prev_ff.start, len: prev_ff.len + merge_len,
                  owner: OWN_FREE, stamp: stamp_ff};
               cmd.vclr0_en   = 1'b1;
               cmd.vclr0_addr = ADDR_W'(e_idx_ff);
            end else begin
               cmd.wr_addr = ADDR_W'(e_idx_ff);
               cmd.wr_data = '{start: e_ff.start, len: merge_len,
                  owner: OWN_FREE, stamp: stamp_ff};
            end
            stamp_in = stamp_ff + 32'd1;
            if (free_kind) begin
               used1_in = sub_used;
            end else begin
               used0_in = sub_used;
            end
            pend_in  = '{status: ST_OK, grant_offset: e_ff.start,
               grant_granules: e_ff.len, kind_used_bytes: sub_used};
            state_in = S_RESP;
         end
         S_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in       = pend_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_INIT;
         end
      endcase

      // pool write: the user must issue it only while idle; the block itself does not enforce this
      if (csr_write_en) begin
         pool_in  = csr_clamped;
         stamp_in = 32'd1;
         used0_in = '0;
         used1_in = '0;
         cmd.init = 1'b1;
         state_in = S_INIT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         cnt_ff       <= '0;
         pool_ff      <= POOL_RESET;
         stamp_ff     <= 32'd1;
         used0_ff     <= '0;
         used1_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         pool_ff      <= pool_in;
         stamp_ff     <= stamp_in;
         used0_ff     <= used0_in;
         used1_ff     <= used1_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff        <= req_in;
      need_ff       <= need_in;
      best_found_ff <= best_found_in;
      best_idx_ff   <= best_idx_in;
      best_ff       <= best_in;
      slot_found_ff <= slot_found_in;
      slot_idx_ff   <= slot_idx_in;
      e_found_ff    <= e_found_in;
      e_idx_ff      <= e_idx_in;
      e_ff          <= e_in;
      prev_found_ff <= prev_found_in;
      prev_idx_ff   <= prev_idx_in;
      prev_ff       <= prev_in;
      next_found_ff <= next_found_in;
      next_idx_ff   <= next_idx_in;
      next_len_ff   <= next_len_in;
      pend_ff       <= pend_in;
      rsp_ff        <= rsp_in;
   end

   assign req_stall   = (state_ff != S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   `BFCA_ASSERT_NXT(a_busy_after_accept, clock, reset, req_valid && !req_stall && !csr_write_en, req_stall, "request accepted but block still idle")
   `BFCA_ASSERT_IMP(a_split_has_best, clock, reset, state_ff == S_ASPLIT, best_found_ff, "grant without a chosen block")
   `BFCA_ASSERT_NXT(a_resp_handoff, clock, reset, (state_ff == S_RESP) && (!rsp_valid_ff || !rsp_stall) && !csr_write_en, rsp_valid && !req_stall, "result not handed to output register")

endmodule
